>>> rtl/core/acpr_pkg.sv
// Shared types, constants and constant tables for the ADS-B CPR position decoder.
// No dependencies; used by every module of the block but acpr_div.
package acpr_pkg;

  localparam int unsigned LatZones = 15;
  localparam int unsigned NumZones = 4 * LatZones;   // 60 even latitude zones
  localparam int unsigned CprBits  = 17;
  localparam int unsigned NlBounds = 58;
  localparam int unsigned QDepth   = 4;
  localparam logic [63:0] DegScale = 64'd36000000000;  // 360 deg in 1e-8 deg
  localparam logic [7:0]  CharHash = 8'h23;
  localparam logic [4:0]  DfExtSquitter = 5'd17;

  typedef enum logic {
    KIND_IDENT = 1'b0,
    KIND_POS   = 1'b1
  } kind_e;

  // one classified item handed from front to back
  typedef struct packed {
    logic        is_pos;
    logic        odd;
    logic [23:0] icao;
    logic [4:0]  tc;
    logic [63:0] callsign;
    logic [16:0] lat_cpr;
    logic [16:0] lon_cpr;
    logic [31:0] ts;
    logic [19:0] tu;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] icao;
    logic [4:0]  tc;
    logic [63:0] callsign;
    logic [31:0] lat;
    logic [31:0] lon;
  } res_t;

  // 6-bit character code to ASCII; '#' marks an illegal code
  function automatic logic [7:0] char_f(input logic [5:0] c);
    logic [7:0] ch;
    if (c >= 6'd1 && c <= 6'd26) begin
      ch = 8'h40 + {2'b00, c};
    end else if (c == 6'd32) begin
      ch = 8'h5F;
    end else if (c >= 6'd48 && c <= 6'd57) begin
      ch = {2'b00, c};
    end else begin
      ch = CharHash;
    end
    return ch;
  endfunction

  // NL zone boundaries in 1e-8 degree
  function automatic logic [63:0] nl_deg_f(input int idx);
    logic [63:0] v;
    case (idx)
      0:  v = 64'd1047047130;  1:  v = 64'd1482817437;  2:  v = 64'd1818626357;
      3:  v = 64'd2102939493;  4:  v = 64'd2354504487;  5:  v = 64'd2582924707;
      6:  v = 64'd2793898710;  7:  v = 64'd2991135686;  8:  v = 64'd3177209708;
      9:  v = 64'd3353993436;  10: v = 64'd3522899598;  11: v = 64'd3685025108;
      12: v = 64'd3841241892;  13: v = 64'd3992256684;  14: v = 64'd4138651832;
      15: v = 64'd4280914012;  16: v = 64'd4419454951;  17: v = 64'd4554626723;
      18: v = 64'd4686733252;  19: v = 64'd4816039128;  20: v = 64'd4942776439;
      21: v = 64'd5067150166;  22: v = 64'd5189342469;  23: v = 64'd5309516153;
      24: v = 64'd5427817472;  25: v = 64'd5544378444;  26: v = 64'd5659318756;
      27: v = 64'd5772747354;  28: v = 64'd5884763776;  29: v = 64'd5995459277;
      30: v = 64'd6104917774;  31: v = 64'd6213216659;  32: v = 64'd6320427479;
      33: v = 64'd6426616523;  34: v = 64'd6531845310;  35: v = 64'd6636171008;
      36: v = 64'd6739646774;  37: v = 64'd6842322022;  38: v = 64'd6944242631;
      39: v = 64'd7045451075;  40: v = 64'd7145986473;  41: v = 64'd7245884545;
      42: v = 64'd7345177442;  43: v = 64'd7443893416;  44: v = 64'd7542056257;
      45: v = 64'd7639684391;  46: v = 64'd7736789461;  47: v = 64'd7833374083;
      48: v = 64'd7929428225;  49: v = 64'd8024923213;  50: v = 64'd8119801349;
      51: v = 64'd8213956981;  52: v = 64'd8307199445;  53: v = 64'd8399173563;
      54: v = 64'd8489166191;  55: v = 64'd8575541621;  56: v = 64'd8653536998;
      57: v = 64'd8700000000;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  // boundary in angle units: floor(deg * 2^ab / 360), evaluated at elaboration
  function automatic logic [63:0] nl_bound_f(input int idx, input int ab);
    logic [63:0] q;
    logic [63:0] r;
    q = nl_deg_f(idx) / DegScale;
    r = nl_deg_f(idx) % DegScale;
    for (int k = 0; k < ab; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DegScale) begin
        r = r - DegScale;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

endpackage

>>> rtl/core/acpr_front.sv
// Front end: decodes DF/TC of an incoming frame, builds the callsign and
// packs position fields into a command. Depends on acpr_pkg.
module acpr_front (
  input  logic [55:0]        frame_high_i,
  input  logic [55:0]        frame_low_i,
  input  logic               frame_ok_i,
  input  logic [31:0]        time_sec_i,
  input  logic [19:0]        time_usec_i,
  output acpr_pkg::cmd_t     cmd_o,
  output logic               keep_o
);
  import acpr_pkg::*;

  logic [4:0]  df;
  logic [4:0]  tc;
  logic [47:0] cs_bits;
  logic [63:0] cs;
  logic        bad_char;
  logic        is_ident;
  logic        is_pos;
  logic [7:0]  ch;

  always_comb begin
    df       = frame_high_i[55:51];
    tc       = frame_high_i[23:19];
    cs_bits  = {frame_high_i[15:0], frame_low_i[55:24]};
    cs       = '0;
    bad_char = 1'b0;
    ch       = '0;
    for (int k = 0; k < 8; k++) begin
      ch = char_f(cs_bits[47 - 6*k -: 6]);
      cs[63 - 8*k -: 8] = ch;
      if (ch == CharHash) bad_char = 1'b1;
    end
    is_ident = (tc >= 5'd1) && (tc <= 5'd4);
    is_pos   = ((tc >= 5'd9) && (tc <= 5'd18)) || ((tc >= 5'd20) && (tc <= 5'd22));
    keep_o   = frame_ok_i && (df == DfExtSquitter) && ((is_ident && !bad_char) || is_pos);

    cmd_o.is_pos   = is_pos;
    cmd_o.odd      = frame_high_i[2];
    cmd_o.icao     = frame_high_i[47:24];
    cmd_o.tc       = tc;
    cmd_o.callsign = cs;
    cmd_o.lat_cpr  = {frame_high_i[1:0], frame_low_i[55:41]};
    cmd_o.lon_cpr  = frame_low_i[40:24];
    cmd_o.ts       = time_sec_i;
    cmd_o.tu       = time_usec_i;
  end

endmodule

>>> rtl/core/acpr_cmd_fifo.sv
// Short command queue between front and back end.
// Depends on acpr_pkg for cmd_t and the depth.
module acpr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  acpr_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output acpr_pkg::cmd_t data_o
);
  import acpr_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> rtl/core/acpr_div.sv
// Restoring divider, one quotient bit per cycle, 6-bit divisor.
// Standalone; used by acpr_back for the zone angle divisions.
module acpr_div #(
  parameter int unsigned ANGLE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic [ANGLE_BITS+5:0] dividend_i,
  input  logic [5:0]            divisor_i,
  output logic                  done_o,
  output logic [ANGLE_BITS-1:0] quotient_o
);
  localparam int unsigned DW = ANGLE_BITS + 6;
  localparam int unsigned CW = $clog2(DW);

  logic [DW-1:0] dvd_q, quo_q;
  logic [5:0]    rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [6:0]    rem_sh, rem_nx;
  logic          ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[ANGLE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= rem_nx[5:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

endmodule

>>> rtl/core/acpr_back.sv
// Back end: holds the even/odd CPR state, runs the global decode sequence
// and owns the result register. Depends on acpr_pkg; drives acpr_div.
module acpr_back #(
  parameter int unsigned ANGLE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            live_time_i,
  input  acpr_pkg::cmd_t        cmd_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  input  logic                  res_pop_i,
  output logic                  res_valid_o,
  output acpr_pkg::res_t        res_o,
  output logic                  div_go_o,
  output logic [ANGLE_BITS+5:0] div_dividend_o,
  output logic [5:0]            div_divisor_o,
  input  logic                  div_done_i,
  input  logic [ANGLE_BITS-1:0] div_quo_i
);
  import acpr_pkg::*;

  localparam int unsigned AB = ANGLE_BITS;
  localparam int unsigned DW = AB + 6;
  localparam logic [AB-1:0] ThreeQuarter = {2'b11, {(AB-2){1'b0}}};
  localparam logic [5:0] NzEven = 6'(NumZones);
  localparam logic [5:0] NzOdd  = 6'(NumZones - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ZONE   = 4'd1;
  localparam logic [3:0] ST_DIVE   = 4'd2;
  localparam logic [3:0] ST_DIVO   = 4'd3;
  localparam logic [3:0] ST_NL     = 4'd4;
  localparam logic [3:0] ST_LONM   = 4'd5;
  localparam logic [3:0] ST_LONMOD = 4'd6;
  localparam logic [3:0] ST_DIVL   = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]  state_q;
  logic [16:0] even_lat_q, even_lon_q, odd_lat_q, odd_lon_q;
  logic [23:0] even_addr_q, odd_addr_q;
  logic [31:0] even_sec_q, odd_sec_q;
  logic [19:0] even_us_q, odd_us_q;
  logic [23:0] icao_q;
  logic [4:0]  tc_q;
  logic [5:0]  z59_q;
  logic [AB-1:0] qe_q, qo_q, mage_q, mago_q, qlon_q;
  logic [5:0]  nl_idx_q, cnte_q, cnto_q, ni_q;
  logic        newer_even_q;
  logic signed [7:0] r_q;
  res_t        res_q;
  logic        res_valid_q;
  logic        div_go_q;
  logic [DW-1:0] div_dvd_q;
  logic [5:0]  div_dvs_q;

  // constant NL boundary table, padded past the last boundary
  logic [AB-1:0] bound_tab [64];
  for (genvar gi = 0; gi < 64; gi++) begin : g_bound
    if (gi < NlBounds) begin : g_real
      localparam logic [63:0] Bound = nl_bound_f(gi, AB);
      assign bound_tab[gi] = Bound[AB-1:0];
    end else begin : g_pad
      assign bound_tab[gi] = '1;
    end
  end

  function automatic logic [DW-1:0] dvd_f(input logic [5:0] zone, input logic [16:0] cpr,
                                          input logic [5:0] n);
    return {zone, cpr, {(AB-17){1'b0}}} | {{(DW-5){1'b0}}, n[5:1]};
  endfunction

  function automatic logic [AB-1:0] mag_f(input logic [AB-1:0] q);
    return (q >= ThreeQuarter) ? (~q + 1'b1) : q;
  endfunction

  // stale and address checks against the partner frame
  logic        slot_free;
  logic [31:0] other_sec, sec_diff;
  logic [23:0] other_addr;
  logic        stale;
  always_comb begin
    slot_free  = !res_valid_q || res_pop_i;
    other_sec  = cmd_i.odd ? even_sec_q : odd_sec_q;
    other_addr = cmd_i.odd ? even_addr_q : odd_addr_q;
    sec_diff   = (cmd_i.ts > other_sec) ? cmd_i.ts - other_sec : other_sec - cmd_i.ts;
    stale      = sec_diff >= {24'd0, live_time_i};
  end

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i && slot_free;

  // latitude zone index
  logic [22:0] pj_e, pj_o;
  logic signed [24:0] jnum;
  logic signed [7:0]  j, z60, z59;
  always_comb begin
    pj_e = 23'(even_lat_q * NzOdd);
    pj_o = 23'(odd_lat_q * NzEven);
    jnum = $signed({2'b00, pj_e}) - $signed({2'b00, pj_o}) + 25'sd65536;
    j    = jnum[24:17];
    z60  = (j < 0) ? j + 8'sd60 : j;
    if (j < -8'sd59) z59 = j + 8'sd118;
    else if (j < 0)  z59 = j + 8'sd59;
    else if (j == 8'sd59) z59 = 8'sd0;
    else             z59 = j;
  end

  // NL count step
  logic hit_e, hit_o;
  logic [5:0] cnte_n, cnto_n, nl;
  always_comb begin
    hit_e  = mage_q >= bound_tab[nl_idx_q];
    hit_o  = mago_q >= bound_tab[nl_idx_q];
    cnte_n = cnte_q + {5'd0, hit_e};
    cnto_n = cnto_q + {5'd0, hit_o};
    nl     = 6'd59 - cnte_q;
  end

  // longitude zone index
  logic [22:0] pm_e, pm_o;
  logic signed [24:0] mnum;
  logic        even_newer;
  logic [5:0]  ni;
  logic signed [7:0] ni_s;
  always_comb begin
    pm_e = 23'(even_lon_q * (nl - 6'd1));
    pm_o = 23'(odd_lon_q * nl);
    mnum = $signed({2'b00, pm_e}) - $signed({2'b00, pm_o}) + 25'sd65536;
    even_newer = (even_sec_q > odd_sec_q) ||
                 ((even_sec_q == odd_sec_q) && (even_us_q >= odd_us_q));
    if (even_newer) ni = nl;
    else ni = (nl > 6'd2) ? nl - 6'd1 : 6'd1;
    ni_s = $signed({2'b00, ni_q});
  end

  // scale to 2^32 units per turn
  logic [AB-1:0] lat_sel;
  logic [31:0]   lat32, lon32;
  assign lat_sel = newer_even_q ? qe_q : qo_q;
  if (AB > 32) begin : g_round
    localparam int unsigned Sh = AB - 32;
    localparam logic [AB-1:0] Half = {{(AB-1){1'b0}}, 1'b1} << (Sh - 1);
    logic [AB-1:0] lat_r, lon_r;
    assign lat_r = lat_sel + Half;
    assign lon_r = qlon_q + Half;
    assign lat32 = lat_r[AB-1:Sh];
    assign lon32 = lon_r[AB-1:Sh];
  end else if (AB == 32) begin : g_same
    assign lat32 = lat_sel;
    assign lon32 = qlon_q;
  end else begin : g_widen
    assign lat32 = {lat_sel, {(32-AB){1'b0}}};
    assign lon32 = {qlon_q, {(32-AB){1'b0}}};
  end

  assign res_valid_o    = res_valid_q;
  assign res_o          = res_q;
  assign div_go_o       = div_go_q;
  assign div_dividend_o = div_dvd_q;
  assign div_divisor_o  = div_dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      even_lat_q  <= '0;
      even_lon_q  <= '0;
      odd_lat_q   <= '0;
      odd_lon_q   <= '0;
      even_addr_q <= '0;
      odd_addr_q  <= '0;
      even_sec_q  <= '0;
      odd_sec_q   <= '0;
      even_us_q   <= '0;
      odd_us_q    <= '0;
      res_valid_q <= 1'b0;
      div_go_q    <= 1'b0;
      nl_idx_q    <= '0;
      cnte_q      <= '0;
      cnto_q      <= '0;
    end else begin
      div_go_q <= 1'b0;
      if (res_pop_i) res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            icao_q <= cmd_i.icao;
            tc_q   <= cmd_i.tc;
            if (!cmd_i.is_pos) begin
              res_valid_q    <= 1'b1;
              res_q.kind     <= KIND_IDENT;
              res_q.icao     <= cmd_i.icao;
              res_q.tc       <= cmd_i.tc;
              res_q.callsign <= cmd_i.callsign;
              res_q.lat      <= '0;
              res_q.lon      <= '0;
            end else begin
              if (cmd_i.odd) begin
                odd_addr_q <= cmd_i.icao;
                odd_sec_q  <= cmd_i.ts;
                odd_us_q   <= cmd_i.tu;
                odd_lat_q  <= cmd_i.lat_cpr;
                odd_lon_q  <= cmd_i.lon_cpr;
                if (stale) even_addr_q <= '0;
              end else begin
                even_addr_q <= cmd_i.icao;
                even_sec_q  <= cmd_i.ts;
                even_us_q   <= cmd_i.tu;
                even_lat_q  <= cmd_i.lat_cpr;
                even_lon_q  <= cmd_i.lon_cpr;
                if (stale) odd_addr_q <= '0;
              end
              if (!stale && (other_addr == cmd_i.icao)) state_q <= ST_ZONE;
            end
          end
        end
        ST_ZONE: begin
          z59_q     <= z59[5:0];
          div_go_q  <= 1'b1;
          div_dvd_q <= dvd_f(z60[5:0], even_lat_q, NzEven);
          div_dvs_q <= NzEven;
          state_q   <= ST_DIVE;
        end
        ST_DIVE: begin
          if (div_done_i) begin
            qe_q      <= div_quo_i;
            mage_q    <= mag_f(div_quo_i);
            div_go_q  <= 1'b1;
            div_dvd_q <= dvd_f(z59_q, odd_lat_q, NzOdd);
            div_dvs_q <= NzOdd;
            state_q   <= ST_DIVO;
          end
        end
        ST_DIVO: begin
          if (div_done_i) begin
            qo_q     <= div_quo_i;
            mago_q   <= mag_f(div_quo_i);
            nl_idx_q <= '0;
            cnte_q   <= '0;
            cnto_q   <= '0;
            state_q  <= ST_NL;
          end
        end
        ST_NL: begin
          cnte_q   <= cnte_n;
          cnto_q   <= cnto_n;
          nl_idx_q <= nl_idx_q + 6'd1;
          if (nl_idx_q == 6'(NlBounds - 1)) begin
            // even and odd latitude must fall in the same NL band
            state_q <= (cnte_n == cnto_n) ? ST_LONM : ST_IDLE;
          end
        end
        ST_LONM: begin
          newer_even_q <= even_newer;
          ni_q         <= ni;
          r_q          <= mnum[24:17];
          state_q      <= ST_LONMOD;
        end
        ST_LONMOD: begin
          if (r_q < 0) begin
            r_q <= r_q + ni_s;
          end else if (r_q >= ni_s) begin
            r_q <= r_q - ni_s;
          end else begin
            div_go_q  <= 1'b1;
            div_dvd_q <= dvd_f(r_q[5:0], newer_even_q ? even_lon_q : odd_lon_q, ni_q);
            div_dvs_q <= ni_q;
            state_q   <= ST_DIVL;
          end
        end
        ST_DIVL: begin
          if (div_done_i) begin
            qlon_q  <= div_quo_i;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            res_valid_q    <= 1'b1;
            res_q.kind     <= KIND_POS;
            res_q.icao     <= icao_q;
            res_q.tc       <= tc_q;
            res_q.callsign <= '0;
            res_q.lat      <= lat32;
            res_q.lon      <= lon32;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/adsb_cpr_position_decoder.sv
// Top level of the ADS-B identification and CPR position decoder.
// Depends on acpr_pkg, acpr_front, acpr_cmd_fifo, acpr_div and acpr_back.
//
// Takes 112-bit Mode-S frames (DF17) with arrival time and a CRC-ok flag.
// Identification items (TC 1-4) give address and an 8-character callsign.
// Airborne position items (TC 9-18, 20-22) update the even/odd CPR store;
// when the partner frame is fresh (seconds apart below live_time) and
// carries the same address, a global decode yields latitude/longitude as
// 32-bit binary angles. A position decode occupies the back end while
// three divisions by the zone count run one bit per cycle in a shared
// divider, the NL band search walks the 58 zone boundaries one per cycle
// and the longitude zone index is reduced into range. A 4-entry command
// queue lets the front end keep taking items while the back end works.
// The back end takes the next item only once the result register is empty
// or being popped in that cycle.
// The configuration channel is always ready; write it only while idle.
module adsb_cpr_position_decoder #(
  parameter int unsigned ANGLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [55:0] frame_high_i,
  input  logic [55:0] frame_low_i,
  input  logic        frame_ok_i,
  input  logic [31:0] time_sec_i,
  input  logic [19:0] time_usec_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [23:0] icao_address_o,
  output logic [4:0]  type_code_o,
  output logic [63:0] callsign_o,
  output logic signed [31:0] latitude_o,
  output logic signed [31:0] longitude_o
);
  import acpr_pkg::*;

  logic [7:0] live_time_q;
  cmd_t       front_cmd, q_cmd;
  logic       front_keep;
  logic       q_full, q_empty, q_pop;
  logic       res_valid;
  res_t       res;
  logic       div_go, div_done;
  logic [ANGLE_BITS+5:0] div_dividend;
  logic [5:0]            div_divisor;
  logic [ANGLE_BITS-1:0] div_quo;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_time_q <= 8'd40;
    end else if (cfg_valid_i) begin
      live_time_q <= cfg_data_i;
    end
  end

  acpr_front u_front (
    .frame_high_i (frame_high_i),
    .frame_low_i  (frame_low_i),
    .frame_ok_i   (frame_ok_i),
    .time_sec_i   (time_sec_i),
    .time_usec_i  (time_usec_i),
    .cmd_o        (front_cmd),
    .keep_o       (front_keep)
  );

  // dropped items are accepted but never enter the queue
  assign full = q_full;

  acpr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && front_keep),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_cmd)
  );

  acpr_div #(.ANGLE_BITS(ANGLE_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  acpr_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .live_time_i    (live_time_q),
    .cmd_i          (q_cmd),
    .cmd_valid_i    (!q_empty),
    .cmd_pop_o      (q_pop),
    .res_pop_i      (pop && res_valid),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .div_go_o       (div_go),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quo_i      (div_quo)
  );

  assign empty          = !res_valid;
  assign kind_o         = res.kind;
  assign icao_address_o = res.icao;
  assign type_code_o    = res.tc;
  assign callsign_o     = res.callsign;
  assign latitude_o     = res.lat;
  assign longitude_o    = res.lon;

endmodule

>>> test/tb.sv
// Testbench for adsb_cpr_position_decoder: drives DF17 frames, predicts
// identification and CPR position reports, and checks them in order.
// Depends on acpr_pkg and the decoder RTL only.
module tb;
  import acpr_pkg::*;

  typedef struct {
    logic [55:0] hi;
    logic [55:0] lo;
    logic        ok;
    logic [31:0] ts;
    logic [19:0] tu;
  } frame_t;

  // predicts the decoder's reports from the frames it accepts
  class cpr_decode_board;
    res_t            reports[$];
    int unsigned     errors;
    logic [7:0]      live_sec;
    longint          bnd[58];
    logic [16:0]     ev_lat, ev_lon, od_lat, od_lon;
    logic [23:0]     ev_addr, od_addr;
    longint          ev_sec, od_sec, ev_us, od_us;
    string           chars;

    function new();
      longint unsigned deg[58] = '{
        64'd1047047130, 64'd1482817437, 64'd1818626357, 64'd2102939493,
        64'd2354504487, 64'd2582924707, 64'd2793898710, 64'd2991135686,
        64'd3177209708, 64'd3353993436, 64'd3522899598, 64'd3685025108,
        64'd3841241892, 64'd3992256684, 64'd4138651832, 64'd4280914012,
        64'd4419454951, 64'd4554626723, 64'd4686733252, 64'd4816039128,
        64'd4942776439, 64'd5067150166, 64'd5189342469, 64'd5309516153,
        64'd5427817472, 64'd5544378444, 64'd5659318756, 64'd5772747354,
        64'd5884763776, 64'd5995459277, 64'd6104917774, 64'd6213216659,
        64'd6320427479, 64'd6426616523, 64'd6531845310, 64'd6636171008,
        64'd6739646774, 64'd6842322022, 64'd6944242631, 64'd7045451075,
        64'd7145986473, 64'd7245884545, 64'd7345177442, 64'd7443893416,
        64'd7542056257, 64'd7639684391, 64'd7736789461, 64'd7833374083,
        64'd7929428225, 64'd8024923213, 64'd8119801349, 64'd8213956981,
        64'd8307199445, 64'd8399173563, 64'd8489166191, 64'd8575541621,
        64'd8653536998, 64'd8700000000};
      logic [127:0] w;
      chars = "#ABCDEFGHIJKLMNOPQRSTUVWXYZ#####_###############0123456789######";
      // boundary in angle units: floor(deg * 2^32 / 360 deg)
      foreach (deg[i]) begin
        w = {64'd0, deg[i]} << 32;
        w = w / 128'd36000000000;
        bnd[i] = longint'(w[63:0]);
      end
      live_sec = 8'd40;
      ev_lat = '0; ev_lon = '0; od_lat = '0; od_lon = '0;
      ev_addr = '0; od_addr = '0;
      ev_sec = 0; od_sec = 0; ev_us = 0; od_us = 0;
      errors = 0;
    endfunction

    function int unsigned nl_of(longint a);
      longint m;
      int unsigned n;
      m = a < 0 ? -a : a;
      n = 59;
      foreach (bnd[i]) if (m >= bnd[i]) n--;
      return n;
    endfunction

    function longint floor17(longint x);
      return ((x + 64 * 131072) >>> 17) - 64;
    endfunction

    function longint wrap_mod(longint x, longint n);
      longint r;
      r = x % n;
      return r < 0 ? r + n : r;
    endfunction

    function longint zone_ang(logic [16:0] cpr, longint zone, longint n);
      longint num;
      num = (zone * 131072 + longint'(cpr)) << 15;
      return (num + n / 2) / n;
    endfunction

    // note an accepted frame and queue the report it should give
    function void note_frame(frame_t f);
      logic [23:0] icao;
      logic [4:0]  tc;
      logic [47:0] bits;
      logic [63:0] cs;
      logic [16:0] latc, lonc;
      logic [7:0]  ch;
      longint      diff, j, lat_e, lat_o, lat, lon, m, ni, nl, turn;
      bit          even_newer;
      res_t        r;
      if (!f.ok || f.hi[55:51] != DfExtSquitter) return;
      icao = f.hi[47:24];
      tc = f.hi[23:19];
      turn = longint'(1) << 32;
      if (tc >= 1 && tc <= 4) begin
        bits = {f.hi[15:0], f.lo[55:24]};
        cs = '0;
        for (int k = 0; k < 8; k++) begin
          ch = chars[bits[47 - 6 * k -: 6]];
          if (ch == CharHash) return;
          cs = {cs[55:0], ch};
        end
        r.kind = KIND_IDENT; r.icao = icao; r.tc = tc; r.callsign = cs;
        r.lat = '0; r.lon = '0;
        reports.push_back(r);
        return;
      end
      if (!((tc >= 9 && tc <= 18) || (tc >= 20 && tc <= 22))) return;
      latc = {f.hi[1:0], f.lo[55:41]};
      lonc = f.lo[40:24];
      if (!f.hi[2]) begin
        ev_addr = icao; ev_sec = f.ts; ev_us = f.tu; ev_lat = latc; ev_lon = lonc;
        diff = ev_sec > od_sec ? ev_sec - od_sec : od_sec - ev_sec;
        if (diff >= live_sec) begin
          od_addr = '0;
          return;
        end
      end else begin
        od_addr = icao; od_sec = f.ts; od_us = f.tu; od_lat = latc; od_lon = lonc;
        diff = od_sec > ev_sec ? od_sec - ev_sec : ev_sec - od_sec;
        if (diff >= live_sec) begin
          ev_addr = '0;
          return;
        end
      end
      if (ev_addr != od_addr) return;
      j = floor17(59 * longint'(ev_lat) - 60 * longint'(od_lat) + 65536);
      lat_e = zone_ang(ev_lat, wrap_mod(j, 60), 60);
      lat_o = zone_ang(od_lat, wrap_mod(j, 59), 59);
      if (lat_e >= turn / 4 * 3) lat_e -= turn;
      if (lat_o >= turn / 4 * 3) lat_o -= turn;
      nl = nl_of(lat_e);
      if (nl != nl_of(lat_o)) return;    // the two frames straddle a zone edge
      even_newer = ev_sec > od_sec || (ev_sec == od_sec && ev_us >= od_us);
      m = floor17(longint'(ev_lon) * (nl - 1) - longint'(od_lon) * nl + 65536);
      if (even_newer) begin
        ni = nl > 1 ? nl : 1;
        lon = zone_ang(ev_lon, wrap_mod(m, ni), ni);
        lat = lat_e;
      end else begin
        ni = nl > 2 ? nl - 1 : 1;
        lon = zone_ang(od_lon, wrap_mod(m, ni), ni);
        lat = lat_o;
      end
      if (lon >= turn / 2) lon -= turn;
      r.kind = KIND_POS; r.icao = icao; r.tc = tc; r.callsign = '0;
      r.lat = lat[31:0]; r.lon = lon[31:0];
      reports.push_back(r);
    endfunction

    function void check_report(res_t a);
      res_t e;
      if (reports.size() == 0) begin
        $display("%0t: unexpected report kind %0d icao %h", $time, a.kind, a.icao);
        errors++;
        return;
      end
      e = reports.pop_front();
      if (a.kind != e.kind) begin
        $display("%0t: kind exp %0d got %0d", $time, e.kind, a.kind); errors++;
      end
      if (a.icao != e.icao) begin
        $display("%0t: icao exp %h got %h", $time, e.icao, a.icao); errors++;
      end
      if (a.tc != e.tc) begin
        $display("%0t: type code exp %0d got %0d", $time, e.tc, a.tc); errors++;
      end
      if (a.callsign != e.callsign) begin
        $display("%0t: callsign exp %h got %h", $time, e.callsign, a.callsign);
        errors++;
      end
      if (a.lat != e.lat) begin
        $display("%0t: latitude exp %h got %h", $time, e.lat, a.lat); errors++;
      end
      if (a.lon != e.lon) begin
        $display("%0t: longitude exp %h got %h", $time, e.lon, a.lon); errors++;
      end
    endfunction
  endclass

  // a full queue plus the item in the back end, each a longest decode, padded
  localparam int unsigned DrainCycles = 1600;
  localparam longint     CycleLimit  = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [55:0] frame_high_i = '0;
  logic [55:0] frame_low_i = '0;
  logic        frame_ok_i = 1'b0;
  logic [31:0] time_sec_i = '0;
  logic [19:0] time_usec_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic [23:0] icao_address_o;
  logic [4:0]  type_code_o;
  logic [63:0] callsign_o;
  logic signed [31:0] latitude_o;
  logic signed [31:0] longitude_o;

  cpr_decode_board board = new();
  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  int unsigned rx_hold = 0;
  longint      cycles = 0;
  logic [31:0] now_sec;
  logic [23:0] fleet[4];

  adsb_cpr_position_decoder u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .push, .full, .frame_high_i, .frame_low_i, .frame_ok_i, .time_sec_i,
    .time_usec_i, .empty, .pop, .kind_o, .icao_address_o, .type_code_o,
    .callsign_o, .latitude_o, .longitude_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL adsb_cpr_position_decoder");
      $finish;
    end
  end

  // report side: random pops, plus a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle);
      end
      @(posedge clk_i);
      if (pop && !empty)
        board.check_report('{kind_e'(kind_o), icao_address_o, type_code_o,
                             callsign_o, latitude_o, longitude_o});
    end
  end

  function automatic frame_t pos_frame(logic [23:0] icao, logic [4:0] tc, bit odd,
                                       logic [16:0] latc, logic [16:0] lonc,
                                       logic [31:0] ts, logic [19:0] tu);
    frame_t f;
    f.hi = {DfExtSquitter, 3'($urandom), icao, tc, 16'($urandom), odd, latc[16:15]};
    f.lo = {latc[14:0], lonc, 24'($urandom)};
    f.ok = 1'b1; f.ts = ts; f.tu = tu;
    return f;
  endfunction

  function automatic frame_t ident_frame(logic [23:0] icao, logic [4:0] tc,
                                         logic [47:0] codes);
    frame_t f;
    f.hi = {DfExtSquitter, 3'($urandom), icao, tc, 3'($urandom), codes[47:32]};
    f.lo = {codes[31:0], 24'($urandom)};
    f.ok = 1'b1; f.ts = $urandom; f.tu = 20'($urandom_range(999999));
    return f;
  endfunction

  // legal character codes: letters, space, digits
  function automatic logic [5:0] good_char();
    int unsigned r;
    r = $urandom_range(36);
    if (r < 26) return 6'(r + 1);
    if (r == 26) return 6'd32;
    return 6'(48 + r - 27);
  endfunction

  task automatic send(frame_t f);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    frame_high_i <= f.hi; frame_low_i <= f.lo; frame_ok_i <= f.ok;
    time_sec_i <= f.ts; time_usec_i <= f.tu;
    do @(posedge clk_i); while (full);
    board.note_frame(f);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // all reports in, then room for queued decodes that yield nothing
  task automatic drain();
    while (board.reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_live(logic [7:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.live_sec = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one random frame: mostly even/odd position tracks, some idents, some noise
  task automatic random_frame();
    frame_t      f;
    logic [47:0] codes;
    int unsigned pick;
    logic [4:0]  tcs[13] = '{9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 20, 21, 22};
    pick = $urandom_range(99);
    if (pick < 70) begin
      now_sec = now_sec + (($urandom_range(19) == 0) ? $urandom_range(300)
                                                      : $urandom_range(3));
      f = pos_frame(($urandom_range(9) == 0) ? 24'($urandom) : fleet[$urandom_range(3)],
                    tcs[$urandom_range(12)], 1'($urandom_range(1)), 17'($urandom),
                    17'($urandom), now_sec, 20'($urandom_range(999999)));
      if ($urandom_range(19) == 0) f.tu = 20'($urandom);
      f.ok = ($urandom_range(19) != 0);
    end else if (pick < 85) begin
      for (int k = 0; k < 8; k++) codes[47 - 6 * k -: 6] = good_char();
      if ($urandom_range(4) == 0) codes[6 * $urandom_range(7) +: 6] = 6'($urandom);
      f = ident_frame(fleet[$urandom_range(3)], 5'($urandom_range(1, 4)), codes);
    end else begin
      f.hi = 56'({$urandom, $urandom}); f.lo = 56'({$urandom, $urandom});
      f.ok = 1'($urandom_range(1)); f.ts = $urandom; f.tu = 20'($urandom);
      if ($urandom_range(1)) f.hi[55:51] = DfExtSquitter;
    end
    send(f);
  endtask

  initial begin
    logic [47:0] codes;
    frame_t      f;
    foreach (fleet[i]) fleet[i] = 24'($urandom);
    now_sec = $urandom;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: idents, ignored frames, pairing rules, CPR extremes
    write_live(8'd40);
    codes = {6'd1, 6'd26, 6'd32, 6'd48, 6'd57, 6'd13, 6'd20, 6'd9};
    send(ident_frame(24'hFFFFFF, 5'd1, codes));
    send(ident_frame(24'h000000, 5'd4, codes));
    send(ident_frame(24'hABCDEF, 5'd2, {6'd0, 42'd0}));          // illegal code
    send(ident_frame(24'hABCDEF, 5'd3, {codes[47:6], 6'd63}));   // illegal code
    f = ident_frame(24'h123456, 5'd1, codes); f.ok = 1'b0; send(f);
    f.ok = 1'b1; f.hi[55:51] = 5'd18; send(f);                    // not DF17
    f.hi = '1; f.lo = '1; send(f);
    f.hi = '0; f.lo = '0; f.hi[55:51] = DfExtSquitter; send(f);   // TC 0
    send(pos_frame(24'h4CA123, 5'd5, 0, 17'h1FFFF, 17'h0, 32'hFFFFFFFF, 20'hFFFFF));
    send(pos_frame(24'h4CA123, 5'd19, 1, 17'h0, 17'h1FFFF, 32'd0, 20'd0));
    send(pos_frame(24'h4CA123, 5'd23, 1, 17'h0, 17'h1FFFF, 32'd0, 20'd0));
    send(pos_frame(24'h4CA123, 5'd9, 0, 17'd93000, 17'd51372, 32'd1000, 20'd5));
    send(pos_frame(24'h4CA123, 5'd9, 1, 17'd74158, 17'd50194, 32'd1001, 20'd9));
    send(pos_frame(24'h4CA123, 5'd18, 0, 17'd93000, 17'd51372, 32'd1001, 20'd9));
    send(pos_frame(24'h4CA123, 5'd22, 0, 17'h0, 17'h0, 32'd1001, 20'd9));
    send(pos_frame(24'h4CA123, 5'd20, 1, 17'h1FFFF, 17'h1FFFF, 32'd1040, 20'd0));
    send(pos_frame(24'h4CA123, 5'd11, 0, 17'h1FFFF, 17'h0, 32'd1079, 20'hFFFFF));
    send(pos_frame(24'h4CA124, 5'd12, 1, 17'h0, 17'h1FFFF, 32'd1079, 20'd0));
    send(pos_frame(24'h4CA124, 5'd12, 0, 17'h10000, 17'h10000, 32'd1080, 20'd0));
    send(pos_frame(24'hFFFFFF, 5'd15, 1, 17'h0FFFF, 17'h0FFFF, 32'hFFFFFFFF, 20'd0));
    send(pos_frame(24'hFFFFFF, 5'd16, 0, 17'h0FFFF, 17'h0FFFF, 32'hFFFFFFFE, 20'd0));
    stop_sending();
    drain();

    // sender busy, receiver sparse; widest pairing window
    write_live(8'd255);
    tx_idle = 10; rx_idle = 58;
    repeat (370) random_frame();
    stop_sending();
    drain();

    // sender sparse, receiver busy; only same-second pairs survive
    write_live(8'd1);
    tx_idle = 58; rx_idle = 10;
    repeat (370) random_frame();
    stop_sending();
    drain();

    // no idling; the receiver first holds off long enough to back up the queue
    write_live(8'($urandom_range(2, 254)));
    tx_idle = 0; rx_idle = 0;
    rx_hold = 3000;
    repeat (370) random_frame();
    stop_sending();
    drain();

    if (board.errors == 0 && board.reports.size() == 0) begin
      $display("PASS adsb_cpr_position_decoder");
    end else begin
      $display("FAIL adsb_cpr_position_decoder");
    end
    $finish;
  end

endmodule

>>> adsb_cpr_position_decoder.f
rtl/core/acpr_pkg.sv
rtl/core/acpr_front.sv
rtl/core/acpr_cmd_fifo.sv
rtl/core/acpr_div.sv
rtl/core/acpr_back.sv
rtl/core/adsb_cpr_position_decoder.sv
test/tb.sv
